// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/chkv_pkg.sv =====
// Package: types and codes of the chained hash key-value table
`default_nettype none
package chkv_pkg;
    typedef enum logic [1:0] {
        CMD_SET = 2'd0,
        CMD_INC = 2'd1,
        CMD_GET = 2'd2,
        CMD_DEL = 2'd3
    } t_cmd;
    typedef enum logic [1:0] {
        ST_MISS = 2'd0,
        ST_HIT  = 2'd1,
        ST_NEW  = 2'd2,
        ST_FULL = 2'd3
    } t_status;
    localparam int unsigned CNT_W = 13;
endpackage
`default_nettype wire

// ===== sv/chkv_if.sv =====
// Interfaces: command, result and configuration channels
`default_nettype none
interface chkv_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] key;
    logic signed [63:0] value;
    modport source (output valid, cmd, key, value, input ready);
    modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface chkv_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [63:0] read_value;
    logic [12:0] entry_count;
    modport source (output valid, status, read_value, entry_count, input ready);
    modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

interface chkv_cfg_if;
    logic       valid;
    logic       ready;
    logic [8:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/chkv_mod.sv =====
// Slot reduction: key modulo slot count, one quotient bit per cycle
`default_nettype none
module chkv_mod #(
    parameter int unsigned SLOT_W = 12,
    parameter int unsigned DIV_W  = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [63:0]       i_key,
    input  wire logic [DIV_W-1:0]  i_div,
    output logic                   o_done,
    output logic [SLOT_W-1:0]      o_slot
);
    logic [63:0]      r_key, n_key;
    logic [DIV_W:0]   r_rem, n_rem;
    logic [DIV_W-1:0] r_div;
    logic [6:0]       r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [DIV_W:0]   w_sh;

    always_comb begin
        w_sh   = {r_rem[DIV_W-1:0], r_key[63]};
        n_key  = {r_key[62:0], 1'b0};
        n_rem  = (w_sh >= {1'b0, r_div}) ? w_sh - {1'b0, r_div} : w_sh;
        n_cnt  = r_cnt - 7'd1;
        n_busy = r_busy && (r_cnt != 7'd1);
        if (i_start) begin
            n_key  = i_key;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= (r_busy || i_start) ? n_cnt : r_cnt;
        end
        if (i_start) r_div <= i_div;
        if (r_busy || i_start) begin
            r_key <= n_key;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_busy && (r_cnt == 7'd1);
    assign o_slot = n_rem[SLOT_W-1:0];
endmodule
`default_nettype wire

// ===== sv/chained_hash_key_value_table.sv =====
// Top level: chained hash key-value table with node pool and free stack
//  channel  | dir | handshake    | payload
//  cmd      | in  | valid/ready  | cmd, key, value
//  res      | out | valid/ready  | status, read_value, entry_count
//  cfg      | in  | valid/ready  | data (buckets in use)
// A command passes slot reduction, a head read, a node read and compare per chain node (one
// more pass when the walk reaches the end of the chain), an update and a result state; the
// next command can be accepted while the result is valid.
// After reset a clearing pass over all MAX_BUCKETS*BUCKET_SIZE head slots clears them; no
// command is taken meanwhile. One command at a time; the update waits while a result is held.
`default_nettype none
module chained_hash_key_value_table #(
    parameter int unsigned BUCKET_SIZE   = 16,
    parameter int unsigned MAX_BUCKETS   = 256,
    parameter int unsigned NODE_CAPACITY = 4096
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    chkv_cmd_if.sink   cmd_ch,
    chkv_res_if.source res_ch,
    chkv_cfg_if.sink   cfg_ch
);
    localparam int unsigned SLOTS  = MAX_BUCKETS * BUCKET_SIZE;
    localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned NODE_W = $clog2(NODE_CAPACITY);
    localparam int unsigned LINK_W = $clog2(NODE_CAPACITY + 1);
    localparam int unsigned DIV_W  = $clog2(SLOTS + 1);
    localparam int unsigned CW     = chkv_pkg::CNT_W;

    typedef enum logic [7:0] {
        S_CLR  = 8'b00000001,
        S_IDLE = 8'b00000010,
        S_MOD  = 8'b00000100,
        S_HEAD = 8'b00001000,
        S_NODE = 8'b00010000,
        S_CHK  = 8'b00100000,
        S_ACT  = 8'b01000000,
        S_OUT  = 8'b10000000
    } t_state;

    logic [LINK_W-1:0] m_head [SLOTS];
    logic [63:0]       m_key  [NODE_CAPACITY];
    logic [63:0]       m_val  [NODE_CAPACITY];
    logic [LINK_W-1:0] m_link [NODE_CAPACITY];
    logic [NODE_W-1:0] m_free [NODE_CAPACITY];

    t_state             r_st;
    logic [SLOT_W:0]    r_clr;
    logic [8:0]         r_bc;
    logic [1:0]         r_cmd;
    logic [63:0]        r_k, r_v;
    logic [SLOT_W-1:0]  r_slot;
    logic [LINK_W-1:0]  r_cur, r_prior, r_hlink;
    logic [LINK_W-1:0]  r_hd_q, r_ln_q;
    logic [63:0]        r_key_q, r_val_q;
    logic [NODE_W-1:0]  r_fr_q;
    logic [NODE_W:0]    r_ftop;
    logic [LINK_W-1:0]  r_fresh;
    logic [CW-1:0]      r_cnt;
    logic [LINK_W-1:0]  r_steps;
    logic               r_rv;
    logic [1:0]         r_ost;
    logic [63:0]        r_orv;
    logic [CW-1:0]      r_ocnt;
    logic               w_done;
    logic [SLOT_W-1:0]  w_slot;
    logic [DIV_W-1:0]   w_div;
    logic [8:0]         w_bc;

    always_comb begin
        w_bc = r_bc;
        if (w_bc == 9'd0) w_bc = 9'd1;
        if (32'(w_bc) > MAX_BUCKETS) w_bc = 9'(MAX_BUCKETS);
        w_div = DIV_W'(32'(w_bc) * BUCKET_SIZE);
    end

    chkv_mod #(.SLOT_W(SLOT_W), .DIV_W(DIV_W)) u_mod (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(r_st == S_IDLE && cmd_ch.valid),
        .i_key(cmd_ch.key), .i_div(w_div),
        .o_done(w_done), .o_slot(w_slot)
    );

    assign cmd_ch.ready = (r_st == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign res_ch.valid = r_rv;
    assign res_ch.status = r_ost;
    assign res_ch.read_value = r_orv;
    assign res_ch.entry_count = r_ocnt;

    logic [NODE_W-1:0] w_ci;
    logic [NODE_W-1:0] w_pi;
    logic              w_have;
    logic [NODE_W-1:0] w_new;
    chkv_pkg::t_status w_ost;
    logic [63:0]       w_orv;
    // first node read of a walk goes straight from the head slot
    assign w_ci = NODE_W'(((r_st == S_NODE && r_steps == '0) ? r_hd_q : r_cur) - LINK_W'(1));
    assign w_pi = NODE_W'(r_prior - LINK_W'(1));
    assign w_have = (r_ftop != '0) || (32'(r_fresh) < NODE_CAPACITY);
    assign w_new = (r_ftop != '0) ? r_fr_q : NODE_W'(r_fresh);

    always_comb begin
        w_ost = chkv_pkg::ST_MISS;
        w_orv = '0;
        case (r_cmd)
            chkv_pkg::CMD_SET: begin
                if (r_cur != '0) w_ost = chkv_pkg::ST_HIT;
                else if (w_have) w_ost = chkv_pkg::ST_NEW;
                else w_ost = chkv_pkg::ST_FULL;
            end
            chkv_pkg::CMD_GET: if (r_cur != '0) begin
                w_ost = chkv_pkg::ST_HIT;
                w_orv = r_val_q;
            end
            default: if (r_cur != '0) w_ost = chkv_pkg::ST_HIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_CLR) m_head[r_clr[SLOT_W-1:0]] <= '0;
        r_hd_q  <= m_head[r_slot];
        r_key_q <= m_key[w_ci];
        r_val_q <= m_val[w_ci];
        r_ln_q  <= m_link[w_ci];
        r_fr_q  <= m_free[NODE_W'(r_ftop - 1'b1)];
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_bc <= 9'd256;
            r_ftop <= '0; r_fresh <= '0; r_cnt <= '0; r_rv <= 1'b0;
        end else begin
            if (cfg_ch.valid) r_bc <= cfg_ch.data;
            if (r_rv && res_ch.ready) r_rv <= 1'b0;
            unique case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (32'(r_clr) == SLOTS - 1) r_st <= S_IDLE;
                end
                S_IDLE: if (cmd_ch.valid) begin
                    r_cmd <= cmd_ch.cmd; r_k <= cmd_ch.key; r_v <= cmd_ch.value;
                    r_st <= S_MOD;
                end
                S_MOD: if (w_done) begin r_slot <= w_slot; r_st <= S_HEAD; end
                S_HEAD: begin r_st <= S_NODE; r_prior <= '0; r_steps <= '0; end
                S_NODE: begin
                    if (r_steps == '0) begin r_cur <= r_hd_q; r_hlink <= r_hd_q; end
                    r_st <= S_CHK;
                end
                S_CHK: begin
                    if (r_cur == '0 || 32'(r_steps) >= NODE_CAPACITY) begin
                        r_cur <= '0; r_prior <= '0; r_st <= S_ACT;
                    end else if (r_key_q == r_k) r_st <= S_ACT;
                    else begin
                        r_prior <= r_cur; r_cur <= r_ln_q;
                        r_steps <= r_steps + 1'b1; r_st <= S_NODE;
                    end
                end
                S_ACT: if (!r_rv || res_ch.ready) begin
                    r_ost <= w_ost; r_orv <= w_orv;
                    case (r_cmd)
                        chkv_pkg::CMD_SET: if (r_cur != '0) begin
                            m_val[w_ci] <= r_v;
                        end else if (w_have) begin
                            m_key[w_new] <= r_k; m_val[w_new] <= r_v;
                            m_link[w_new] <= r_hlink;
                            m_head[r_slot] <= LINK_W'(w_new) + LINK_W'(1);
                            if (r_ftop != '0) r_ftop <= r_ftop - 1'b1;
                            else r_fresh <= r_fresh + 1'b1;
                            r_cnt <= r_cnt + 1'b1;
                        end
                        chkv_pkg::CMD_INC: if (r_cur != '0) begin
                            m_val[w_ci] <= r_val_q + r_v;
                        end
                        chkv_pkg::CMD_DEL: if (r_cur != '0) begin
                            if (r_prior == '0) m_head[r_slot] <= r_ln_q;
                            else m_link[w_pi] <= r_ln_q;
                            m_free[r_ftop[NODE_W-1:0]] <= w_ci;
                            r_ftop <= r_ftop + 1'b1;
                            if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                        end
                        default: ;
                    endcase
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    r_ocnt <= r_cnt; r_rv <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/chkv_checker.sv =====
// Port-level checker for the chained hash key-value table, with bind
`default_nettype none
`include "assert_macros.svh"
module chkv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        cmd_ready,
    input wire logic        cmd_valid,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  res_status,
    input wire logic [63:0] res_read_value,
    input wire logic [12:0] res_entry_count
);
    logic w_not_hit;
    assign w_not_hit = (res_status != chkv_pkg::ST_HIT);

    `CHK_IMPL(a_rv_zero, i_clk, i_rst_n, res_valid && w_not_hit, res_read_value == '0)
    `CHK_IMPL(a_cnt_range, i_clk, i_rst_n, res_valid, res_entry_count <= 13'd4096)
    `CHK_NEXT(a_busy, i_clk, i_rst_n, cmd_valid && cmd_ready, !cmd_ready)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid && $stable(res_status))
endmodule

bind chained_hash_key_value_table chkv_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .cmd_ready(cmd_ch.ready), .cmd_valid(cmd_ch.valid),
    .res_valid(res_ch.valid), .res_ready(res_ch.ready),
    .res_status(res_ch.status), .res_read_value(res_ch.read_value),
    .res_entry_count(res_ch.entry_count)
);
`default_nettype wire

// ===== bench/tb_chained_hash_key_value_table.sv =====
// Testbench: random and directed commands on the chained hash table, checked against a predictor
`default_nettype none
module tb_chained_hash_key_value_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 4096;
    localparam int NODES = 4096;

    typedef struct packed {
        chkv_pkg::t_status  status;
        logic signed [63:0] read_value;
        logic [12:0]        entry_count;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    chkv_cmd_if cmd_ch ();
    chkv_res_if res_ch ();
    chkv_cfg_if cfg_ch ();

    chained_hash_key_value_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .cmd_ch(cmd_ch.sink), .res_ch(res_ch.source), .cfg_ch(cfg_ch.sink)
    );

    // predictor state
    logic [8:0]  buckets_cfg;
    logic [12:0] heads [SLOTS];
    logic [63:0] nkey  [NODES];
    logic [63:0] nval  [NODES];
    logic [12:0] nlink [NODES];
    logic [11:0] freestk [NODES];
    int unsigned free_depth, fresh_idx, held;

    t_answer answers_due [$];
    int errors = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_on = 1'b0;
    longint cycles = 0;
    logic [63:0] keys_used [$];

    function automatic t_answer predict_table(chkv_pkg::t_cmd c, logic [63:0] k,
                                              logic [63:0] v);
        int unsigned b, slot, lnk, prv, hit, steps, node;
        t_answer a;
        b = 32'(buckets_cfg);
        if (b == 0) b = 1;
        if (b > 256) b = 256;
        slot = 32'(k % (64'(b) * 64'd16));
        lnk = 32'(heads[slot]);
        prv = 0; hit = 0; steps = 0;
        while (lnk != 0 && steps < NODES) begin
            if (nkey[lnk-1] == k) begin
                hit = lnk;
                break;
            end
            prv = lnk;
            lnk = 32'(nlink[lnk-1]);
            steps++;
        end
        if (hit == 0) prv = 0;
        a.status = chkv_pkg::ST_MISS;
        a.read_value = '0;
        case (c)
            chkv_pkg::CMD_SET: begin
                if (hit != 0) begin
                    nval[hit-1] = v;
                    a.status = chkv_pkg::ST_HIT;
                end else if (free_depth > 0 || fresh_idx < NODES) begin
                    if (free_depth > 0) begin
                        free_depth--;
                        node = 32'(freestk[free_depth]);
                    end else begin
                        node = fresh_idx++;
                    end
                    nkey[node] = k;
                    nval[node] = v;
                    nlink[node] = heads[slot];
                    heads[slot] = 13'(node + 1);
                    held++;
                    a.status = chkv_pkg::ST_NEW;
                end else begin
                    a.status = chkv_pkg::ST_FULL;
                end
            end
            chkv_pkg::CMD_INC: if (hit != 0) begin
                nval[hit-1] = nval[hit-1] + v;
                a.status = chkv_pkg::ST_HIT;
            end
            chkv_pkg::CMD_GET: if (hit != 0) begin
                a.read_value = nval[hit-1];
                a.status = chkv_pkg::ST_HIT;
            end
            default: if (hit != 0) begin
                if (prv == 0) heads[slot] = nlink[hit-1];
                else nlink[prv-1] = nlink[hit-1];
                freestk[free_depth] = 12'(hit - 1);
                free_depth++;
                if (held > 0) held--;
                a.status = chkv_pkg::ST_HIT;
            end
        endcase
        a.entry_count = held[12:0];
        return a;
    endfunction

    // valid stays up after an accept until the next item or an idle cycle replaces it
    task automatic send_cmd(chkv_pkg::t_cmd c, logic [63:0] k, logic [63:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= c;
        cmd_ch.key <= k;
        cmd_ch.value <= v;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        answers_due.push_back(predict_table(c, k, v));
        if (c == chkv_pkg::CMD_SET && keys_used.size() < 512) keys_used.push_back(k);
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_buckets(logic [8:0] d);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= d;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        buckets_cfg = d;
    endtask

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(9);
        if (r < 6 && keys_used.size() != 0)
            return keys_used[$urandom_range(keys_used.size() - 1)];
        if (r < 8) return 64'($urandom_range(300));
        return {$urandom, $urandom};
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_answer want;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    $display("%0t: result with nothing expected, got %0d/%0d/%0d", $time,
                             res_ch.status, res_ch.read_value, res_ch.entry_count);
                    errors++;
                end else begin
                    want = answers_due.pop_front();
                    if (res_ch.status !== want.status) begin
                        $display("%0t: status exp %0d got %0d", $time, want.status,
                                 res_ch.status);
                        errors++;
                    end
                    if (res_ch.read_value !== want.read_value) begin
                        $display("%0t: read_value exp %0d got %0d", $time,
                                 want.read_value, res_ch.read_value);
                        errors++;
                    end
                    if (res_ch.entry_count !== want.entry_count) begin
                        $display("%0t: entry_count exp %0d got %0d", $time,
                                 want.entry_count, res_ch.entry_count);
                        errors++;
                    end
                end
            end
            if (hold_on) begin
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > 3_000_000) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_cmd(chkv_pkg::CMD_GET, 64'd5, 64'd0);
        send_cmd(chkv_pkg::CMD_INC, 64'd5, 64'd1);
        send_cmd(chkv_pkg::CMD_DEL, 64'd5, 64'd0);
        send_cmd(chkv_pkg::CMD_SET, 64'd0, 64'h8000_0000_0000_0000);
        send_cmd(chkv_pkg::CMD_SET, '1, 64'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(chkv_pkg::CMD_INC, '1, 64'd1);
        send_cmd(chkv_pkg::CMD_GET, '1, 64'd0);
        send_cmd(chkv_pkg::CMD_SET, 64'd4096, 64'hAAAA_5555_AAAA_5555);
        send_cmd(chkv_pkg::CMD_SET, 64'd8192, 64'h5555_AAAA_5555_AAAA);
        send_cmd(chkv_pkg::CMD_SET, 64'd4096, -64'sd3);
        send_cmd(chkv_pkg::CMD_INC, 64'd8192, -64'sd1);
        send_cmd(chkv_pkg::CMD_GET, 64'd4096, 64'd0);
        send_cmd(chkv_pkg::CMD_DEL, 64'd4096, 64'd0);
        send_cmd(chkv_pkg::CMD_GET, 64'd0, 64'd0);
        send_cmd(chkv_pkg::CMD_GET, 64'd8192, 64'd0);
        send_cmd(chkv_pkg::CMD_SET, 64'd12288, 64'd9);
        send_cmd(chkv_pkg::CMD_DEL, 64'd0, 64'd0);
        send_cmd(chkv_pkg::CMD_DEL, 64'd12288, 64'd0);
        send_cmd(chkv_pkg::CMD_DEL, 64'd8192, 64'd0);
    endtask

    task automatic test_random(int n);
        int r;
        chkv_pkg::t_cmd c;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            c = r < 40 ? chkv_pkg::CMD_SET : r < 60 ? chkv_pkg::CMD_INC :
                r < 80 ? chkv_pkg::CMD_GET : chkv_pkg::CMD_DEL;
            send_cmd(c, pick_key(), {$urandom, $urandom});
        end
    endtask

    task automatic test_bucket_settings();
        write_buckets(9'd1);
        test_random(60);
        write_buckets(9'd0);
        test_random(40);
        write_buckets(9'd511);
        test_random(40);
        write_buckets(9'd3);
        test_random(60);
    endtask

    task automatic test_backpressure();
        drain();
        fork
            begin
                hold_on <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_on <= 1'b0;
            end
            test_random(10);
        join
        drain();
    endtask

    task automatic test_idling();
        write_buckets(9'd256);
        send_idle_pct = 6; recv_idle_pct = 82;
        test_random(130);
        send_idle_pct = 82; recv_idle_pct = 6;
        test_random(130);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(130);
    endtask

    initial begin
        buckets_cfg = 9'd256;
        foreach (heads[i]) heads[i] = '0;
        free_depth = 0; fresh_idx = 0; held = 0;
        cmd_ch.valid = 1'b0; cmd_ch.cmd = chkv_pkg::CMD_SET; cmd_ch.key = '0;
        cmd_ch.value = '0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_bucket_settings();
        test_backpressure();
        test_idling();
        drain();
        $display("Ran %0d results over bucket counts 1, 0, 511, 3 and 256,", results_seen);
        $display("with stalls on both sides and one long receiver hold-off.");
        if (errors == 0 && answers_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/chkv_pkg.sv
sv/chkv_if.sv
sv/chkv_mod.sv
sv/chained_hash_key_value_table.sv
sv/chkv_checker.sv
bench/tb_chained_hash_key_value_table.sv
